/* hdl/ptt_pkg.sv */
// ptt_pkg: shared types and constants of the periodic timer table
// no dependencies
package ptt_pkg;
  localparam int TableDepth = 16;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_REMOVE_ID = 3'd2;
  localparam logic [2:0] OP_REMOVE_OWNER = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;

  localparam logic [1:0] KIND_FIRE = 2'd0;
  localparam logic [1:0] KIND_ACK = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [2:0] op;
    logic [31:0] now_time;
    logic [15:0] timer_id;
    logic [7:0] owner_id;
    logic [31:0] period;
    logic signed [16:0] call_limit;
  } cmd_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0] owner;
    logic [31:0] period;
    logic [31:0] last_time;
    logic [15:0] count;
    logic signed [16:0] limit;
  } entry_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [15:0] fired_id;
    logic [7:0] fired_owner;
    logic [1:0] status;
    logic last;
  } result_t;
endpackage

/* hdl/ptt_front.sv */
// ptt_front: input stage, drops unknown ops and queues commands (two entries)
// depends on ptt_pkg
module ptt_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ptt_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_pop,
  output ptt_pkg::cmd_t q_cmd
);
  ptt_pkg::cmd_t mem_r [2];
  logic rd_r, wr_r;
  logic [1:0] cnt_r;
  logic push, known;

  assign in_stall = (cnt_r == 2'd2);
  assign known = (in_cmd.op <= ptt_pkg::OP_QUERY);
  assign push = in_valid && !in_stall && known;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= in_cmd;
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (q_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

/* hdl/ptt_back.sv */
// ptt_back: timer table and sequencer, one result register, one slot per cycle
// while not stalled; depends on ptt_pkg
module ptt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_pop,
  input  ptt_pkg::cmd_t    q_cmd,
  output logic             out_valid,
  input  logic             out_stall,
  output ptt_pkg::result_t out_res
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  ptt_pkg::entry_t tab_r [ptt_pkg::TableDepth];
  logic [ptt_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic [ptt_pkg::CntW-1:0] idx_r, idx_nxt;
  logic [ptt_pkg::CntW-1:0] sh_r, sh_nxt;
  ptt_pkg::cmd_t cmd_r;
  logic any_r, any_nxt;
  logic ov_r, ov_nxt;
  ptt_pkg::result_t res_r, res_nxt;

  ptt_pkg::entry_t cur;
  logic [ptt_pkg::IdxW-1:0] ci, si;
  logic [31:0] diff;
  logic [15:0] cnt_inc;
  logic due, drop, slot_free, done, match_id;
  logic wr_cur, do_shift, do_add;

  assign ci = idx_r[ptt_pkg::IdxW-1:0];
  assign si = sh_r[ptt_pkg::IdxW-1:0];
  assign cur = tab_r[ci];
  assign diff = cmd_r.now_time - cur.last_time;
  assign due = (diff >= cur.period);
  assign cnt_inc = (cur.count == 16'hFFFF) ? cur.count : cur.count + 16'd1;
  assign drop = !cur.limit[16] && ({1'b0, cnt_inc} >= cur.limit);
  assign match_id = (cur.id == cmd_r.timer_id);
  assign done = (idx_r >= cnt_r);
  assign slot_free = !ov_r || !out_stall;
  assign out_valid = ov_r;
  assign out_res = res_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    sh_nxt = sh_r;
    any_nxt = any_r;
    ov_nxt = ov_r && out_stall;
    res_nxt = res_r;
    q_pop = 1'b0;
    wr_cur = 1'b0;
    do_shift = 1'b0;
    do_add = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          idx_nxt = '0;
          any_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (slot_free) begin
          case (cmd_r.op)
            ptt_pkg::OP_TICK: begin
              if (done) begin
                ov_nxt = 1'b1;
                res_nxt = '{ptt_pkg::KIND_ACK, 16'd0, 8'd0, ptt_pkg::ST_OK, 1'b1};
                state_nxt = S_IDLE;
              end else if (due) begin
                ov_nxt = 1'b1;
                res_nxt = '{ptt_pkg::KIND_FIRE, cur.id, cur.owner, ptt_pkg::ST_OK, 1'b0};
                if (drop) begin
                  sh_nxt = idx_r;
                  state_nxt = S_SHIFT;
                end else begin
                  wr_cur = 1'b1;
                  idx_nxt = idx_r + 1'b1;
                end
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
            ptt_pkg::OP_ADD: begin
              ov_nxt = 1'b1;
              state_nxt = S_IDLE;
              if (cnt_r == ptt_pkg::CntW'(ptt_pkg::TableDepth)) begin
                res_nxt = '{ptt_pkg::KIND_ACK, cmd_r.timer_id, cmd_r.owner_id,
                            ptt_pkg::ST_FULL, 1'b1};
              end else begin
                do_add = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
                res_nxt = '{ptt_pkg::KIND_ACK, cmd_r.timer_id, cmd_r.owner_id,
                            ptt_pkg::ST_OK, 1'b1};
              end
            end
            ptt_pkg::OP_REMOVE_OWNER: begin
              if (done) begin
                ov_nxt = 1'b1;
                res_nxt = '{ptt_pkg::KIND_ACK, cmd_r.timer_id, cmd_r.owner_id,
                            any_r ? ptt_pkg::ST_OK : ptt_pkg::ST_NOT_FOUND, 1'b1};
                state_nxt = S_IDLE;
              end else if (cur.owner == cmd_r.owner_id) begin
                any_nxt = 1'b1;
                sh_nxt = idx_r;
                state_nxt = S_SHIFT;
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
            default: begin
              // remove by id and query share the search
              if (done || match_id) begin
                ov_nxt = 1'b1;
                state_nxt = S_IDLE;
                res_nxt.kind = (cmd_r.op == ptt_pkg::OP_QUERY) ?
                               ptt_pkg::KIND_QUERY : ptt_pkg::KIND_ACK;
                res_nxt.fired_id = cmd_r.timer_id;
                res_nxt.fired_owner = done ? 8'd0 : cur.owner;
                res_nxt.status = done ? ptt_pkg::ST_NOT_FOUND : ptt_pkg::ST_OK;
                res_nxt.last = 1'b1;
                if (!done && cmd_r.op == ptt_pkg::OP_REMOVE_ID) begin
                  sh_nxt = idx_r;
                  state_nxt = S_SHIFT;
                end
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
          endcase
        end
      end
      S_SHIFT: begin
        // compaction, one slot per cycle
        if (sh_r + 1'b1 >= cnt_r) begin
          cnt_nxt = cnt_r - 1'b1;
          state_nxt = (cmd_r.op == ptt_pkg::OP_REMOVE_ID) ? S_IDLE : S_SCAN;
        end else begin
          do_shift = 1'b1;
          sh_nxt = sh_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && q_valid) cmd_r <= q_cmd;
    res_r <= res_nxt;
    if (wr_cur) begin
      tab_r[ci].last_time <= cmd_r.now_time;
      tab_r[ci].count <= cnt_inc;
    end
    if (do_shift) tab_r[si] <= tab_r[si + 1'b1];
    if (do_add) tab_r[cnt_r[ptt_pkg::IdxW-1:0]] <= '{cmd_r.timer_id, cmd_r.owner_id,
        cmd_r.period, cmd_r.now_time, 16'd0, cmd_r.call_limit};
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      idx_r <= '0;
      sh_r <= '0;
      any_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      sh_r <= sh_nxt;
      any_r <= any_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule

/* hdl/periodic_timer_table.sv */
// periodic_timer_table: top level of the multi-channel periodic timer table
// depends on ptt_pkg, ptt_front, ptt_back
//
// channel | ports                                             | flow
// input   | in_valid in_stall in_op .. in_call_limit          | into block
// result  | out_valid out_stall out_kind .. out_last          | out of block
//
// a transfer is stored in a two-entry queue; the back part pops it into its
// command register, then walks the table one slot per cycle unless a held result
// stalls it; a tick visits every entry and compacts after each one it drops;
// add appends; remove by id and query stop at a match, remove by id compacts
// reset (rst_n low, synchronous) empties the table and the queue
// out_stall holds the result and the scan; the queue takes transfers until full
module periodic_timer_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_op,
  input  logic [31:0]        in_now_time,
  input  logic [15:0]        in_timer_id,
  input  logic [7:0]         in_owner_id,
  input  logic [31:0]        in_period,
  input  logic signed [16:0] in_call_limit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [15:0]        out_fired_id,
  output logic [7:0]         out_fired_owner,
  output logic [1:0]         out_status,
  output logic               out_last
);
  ptt_pkg::cmd_t in_cmd, q_cmd;
  ptt_pkg::result_t res;
  logic q_valid, q_pop;

  // gather input fields into one command word
  assign in_cmd = '{in_op, in_now_time, in_timer_id, in_owner_id, in_period, in_call_limit};

  ptt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
  );

  // back part: table scan, compaction and result register
  ptt_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .out_valid(out_valid), .out_stall(out_stall), .out_res(res)
  );

  assign out_kind = res.kind;
  assign out_fired_id = res.fired_id;
  assign out_fired_owner = res.fired_owner;
  assign out_status = res.status;
  assign out_last = res.last;
endmodule

/* test/periodic_timer_table_tb.sv */
// periodic_timer_table_tb: self-checking regression of the periodic timer table
// depends on ptt_pkg and periodic_timer_table; keeps its own model of the table
`timescale 1ns / 1ps

module periodic_timer_table_tb;
  localparam logic [2:0] OP_BAD_LO = 3'd5;
  localparam logic [2:0] OP_BAD_HI = 3'd7;

  // expected result held by the model
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] id;
    logic [7:0]  owner;
    logic [1:0]  status;
    logic        last;
  } outcome_t;

  class timer_scoreboard;
    ptt_pkg::entry_t tbl[ptt_pkg::TableDepth];
    int         live;
    outcome_t   pending[$];
    int         errors;

    function void clear();
      live = 0;
      pending.delete();
      errors = 0;
    endfunction

    function void drop(int pos);
      for (int j = pos; j + 1 < live; j++) tbl[j] = tbl[j + 1];
      live--;
    endfunction

    function int find(logic [15:0] id);
      for (int i = 0; i < live; i++) if (tbl[i].id == id) return i;
      return -1;
    endfunction

    function void push(logic [1:0] k, logic [15:0] id, logic [7:0] ow,
                       logic [1:0] st, logic l);
      outcome_t o;
      o.kind = k; o.id = id; o.owner = ow; o.status = st; o.last = l;
      pending.insert(pending.size(), o);
    endfunction

    // advances the table by one accepted command
    function void note_command(ptt_pkg::cmd_t c);
      int i;
      int pos;
      bit any;
      case (c.op)
        ptt_pkg::OP_TICK: begin
          i = 0;
          while (i < live) begin
            if (c.now_time - tbl[i].last_time < tbl[i].period) begin
              i++;
            end else begin
              push(ptt_pkg::KIND_FIRE, tbl[i].id, tbl[i].owner, ptt_pkg::ST_OK, 1'b0);
              tbl[i].last_time = c.now_time;
              if (tbl[i].count != 16'hffff) tbl[i].count++;
              if (tbl[i].limit >= 0 && $signed({1'b0, tbl[i].count}) >= tbl[i].limit)
                drop(i);
              else
                i++;
            end
          end
          push(ptt_pkg::KIND_ACK, 16'd0, 8'd0, ptt_pkg::ST_OK, 1'b1);
        end
        ptt_pkg::OP_ADD: begin
          if (live >= ptt_pkg::TableDepth) begin
            push(ptt_pkg::KIND_ACK, c.timer_id, c.owner_id, ptt_pkg::ST_FULL, 1'b1);
          end else begin
            tbl[live] = '{id: c.timer_id, owner: c.owner_id, period: c.period,
                          last_time: c.now_time, count: 16'd0, limit: c.call_limit};
            live++;
            push(ptt_pkg::KIND_ACK, c.timer_id, c.owner_id, ptt_pkg::ST_OK, 1'b1);
          end
        end
        ptt_pkg::OP_REMOVE_ID: begin
          pos = find(c.timer_id);
          if (pos < 0) begin
            push(ptt_pkg::KIND_ACK, c.timer_id, 8'd0, ptt_pkg::ST_NOT_FOUND, 1'b1);
          end else begin
            push(ptt_pkg::KIND_ACK, c.timer_id, tbl[pos].owner, ptt_pkg::ST_OK, 1'b1);
            drop(pos);
          end
        end
        ptt_pkg::OP_REMOVE_OWNER: begin
          any = 0;
          i = 0;
          while (i < live) begin
            if (tbl[i].owner == c.owner_id) begin
              drop(i);
              any = 1;
            end else begin
              i++;
            end
          end
          push(ptt_pkg::KIND_ACK, c.timer_id, c.owner_id,
               any ? ptt_pkg::ST_OK : ptt_pkg::ST_NOT_FOUND, 1'b1);
        end
        ptt_pkg::OP_QUERY: begin
          pos = find(c.timer_id);
          if (pos < 0)
            push(ptt_pkg::KIND_QUERY, c.timer_id, 8'd0, ptt_pkg::ST_NOT_FOUND, 1'b1);
          else
            push(ptt_pkg::KIND_QUERY, c.timer_id, tbl[pos].owner, ptt_pkg::ST_OK, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_result(outcome_t got);
      outcome_t e;
      if (pending.size() == 0) begin
        $error("unexpected result kind %0d id %0h", got.kind, got.id);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.kind !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, got.kind); errors++;
      end
      if (got.id !== e.id) begin
        $error("fired_id: expected %0h, got %0h", e.id, got.id); errors++;
      end
      if (got.owner !== e.owner) begin
        $error("fired_owner: expected %0h, got %0h", e.owner, got.owner); errors++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status); errors++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_op = '0;
  logic [31:0] in_now_time = '0;
  logic [15:0] in_timer_id = '0;
  logic [7:0] in_owner_id = '0;
  logic [31:0] in_period = '0;
  logic signed [16:0] in_call_limit = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [15:0] out_fired_id;
  logic [7:0] out_fired_owner;
  logic [1:0] out_status;
  logic out_last;

  periodic_timer_table DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  timer_scoreboard sb = new();

  // idle percentages per side, and a long receiver hold-off request
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  int hold_cycles = 0;
  logic [31:0] clock_ms = 32'd1000;
  logic [15:0] sent_ids[$];

  // receiver: random stall, or a long counted hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_cycles <= 400;
      hold_req <= 0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result transfers are checked at the rising edge
  always @(posedge clk) begin
    outcome_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind = out_kind; got.id = out_fired_id; got.owner = out_fired_owner;
      got.status = out_status; got.last = out_last;
      sb.check_result(got);
    end
  end

  // offers one command and waits for its transfer; valid stays up for the next one
  task automatic send_cmd(ptt_pkg::cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= c.op; in_now_time <= c.now_time; in_timer_id <= c.timer_id;
    in_owner_id <= c.owner_id; in_period <= c.period; in_call_limit <= c.call_limit;
    do @(posedge clk); while (in_stall);
    sb.note_command(c);
    @(negedge clk);
  endtask

  function automatic ptt_pkg::cmd_t make_cmd(logic [2:0] op, logic [31:0] t,
                                             logic [15:0] id, logic [7:0] ow,
                                             logic [31:0] per,
                                             logic signed [16:0] lim);
    ptt_pkg::cmd_t c;
    c.op = op; c.now_time = t; c.timer_id = id; c.owner_id = ow;
    c.period = per; c.call_limit = lim;
    return c;
  endfunction

  // mostly well-formed traffic: adds of known ids, ticks with advancing time
  task automatic random_cmd();
    int r;
    ptt_pkg::cmd_t c;
    logic [15:0] id;
    r = $urandom_range(99);
    clock_ms = clock_ms + $urandom_range(60);
    id = (sent_ids.size() > 0 && $urandom_range(3) != 0) ?
         sent_ids[$urandom_range(sent_ids.size() - 1)] : 16'($urandom);
    c = make_cmd(ptt_pkg::OP_TICK, clock_ms, id, 8'($urandom_range(7)),
                 $urandom_range(120), $signed(17'($urandom_range(6))) - 17'sd1);
    if (r < 35) begin
      c.op = ptt_pkg::OP_TICK;
      if ($urandom_range(9) == 0) c.now_time = $urandom;
    end else if (r < 65) begin
      c.op = ptt_pkg::OP_ADD;
      if ($urandom_range(9) == 0) c.period = $urandom;
      if ($urandom_range(9) == 0) c.call_limit = 17'($urandom);
      if ($urandom_range(4) == 0) c.owner_id = 8'($urandom);
      sent_ids.insert(sent_ids.size(), c.timer_id);
      if (sent_ids.size() > 24) void'(sent_ids.pop_front());
    end else if (r < 77) begin
      c.op = ptt_pkg::OP_REMOVE_ID;
    end else if (r < 85) begin
      c.op = ptt_pkg::OP_REMOVE_OWNER;
    end else if (r < 96) begin
      c.op = ptt_pkg::OP_QUERY;
    end else begin
      c.op = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
    end
    send_cmd(c);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  initial begin
    sb.clear();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, every op, special cases
    send_cmd(make_cmd(ptt_pkg::OP_TICK, 32'd0, 16'd0, 8'd0, 32'd0, 17'sd0));
    send_cmd(make_cmd(ptt_pkg::OP_QUERY, 32'd0, 16'hffff, 8'd0, 32'd0, 17'sd0));
    send_cmd(make_cmd(ptt_pkg::OP_ADD, 32'hffffffff, 16'hffff, 8'hff, 32'd0, -17'sd1));
    send_cmd(make_cmd(ptt_pkg::OP_ADD, 32'd0, 16'h0000, 8'h00, 32'hffffffff, 17'sd65535));
    send_cmd(make_cmd(ptt_pkg::OP_ADD, 32'd5, 16'h1234, 8'h01, 32'd10, 17'sd0));
    send_cmd(make_cmd(ptt_pkg::OP_ADD, 32'd5, 16'h1234, 8'h02, 32'd3, 17'sd2));
    send_cmd(make_cmd(ptt_pkg::OP_TICK, 32'd20, 16'haaaa, 8'h55, 32'h5555, 17'sd1));
    send_cmd(make_cmd(ptt_pkg::OP_QUERY, 32'd0, 16'h1234, 8'd0, 32'd0, 17'sd0));
    send_cmd(make_cmd(ptt_pkg::OP_TICK, 32'd4, 16'd0, 8'd0, 32'd0, 17'sd0));
    send_cmd(make_cmd(ptt_pkg::OP_REMOVE_ID, 32'd0, 16'h9999, 8'd0, 32'd0, 17'sd0));
    send_cmd(make_cmd(ptt_pkg::OP_REMOVE_ID, 32'd0, 16'h0000, 8'd0, 32'd0, 17'sd0));
    send_cmd(make_cmd(ptt_pkg::OP_REMOVE_OWNER, 32'd0, 16'h7777, 8'hee, 32'd0, 17'sd0));
    send_cmd(make_cmd(ptt_pkg::OP_REMOVE_OWNER, 32'd0, 16'h7777, 8'hff, 32'd0, 17'sd0));
    send_cmd(make_cmd(OP_BAD_LO, 32'd0, 16'd0, 8'd0, 32'd0, 17'sd0));
    send_cmd(make_cmd(OP_BAD_HI, 32'd0, 16'd0, 8'd0, 32'd0, 17'sd0));
    // fill past capacity with zero-period unlimited timers, then tick them all
    for (int i = 0; i < ptt_pkg::TableDepth + 1; i++)
      send_cmd(make_cmd(ptt_pkg::OP_ADD, 32'd100, 16'(i), 8'(i % 3), 32'd0, -17'sd1));
    send_cmd(make_cmd(ptt_pkg::OP_TICK, 32'd101, 16'd0, 8'd0, 32'd0, 17'sd0));
    send_cmd(make_cmd(ptt_pkg::OP_REMOVE_OWNER, 32'd0, 16'd0, 8'd1, 32'd0, 17'sd0));
    drain();

    // random phases with different idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 77 : 36) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 77 : 36) : 0;
      if (ph == 0) hold_req = 1;   // long hold-off while commands keep coming
      for (int n = 0; n < 62; n++) random_cmd();
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("periodic_timer_table regression: pass");
    end else begin
      $display("periodic_timer_table regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("periodic_timer_table regression: fail");
    $finish;
  end
endmodule
